### rtl/ucd_pkg.sv
`default_nettype none
package ucd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W = 21;
	localparam int unsigned PAY_W = 7;
	localparam int unsigned CONT_BITS = 6;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CP_W-1:0] SUBST_CP = CP_W'(8'h3F);

	// Kind of work handed from the classifier to the assembler
	typedef enum logic [1:0] {
		OP_ASCII,
		OP_LEAD,
		OP_CONT,
		OP_BAD
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic              last;
		logic [PAY_W-1:0]  payload;
	} op_t;

	typedef struct packed {
		logic push;
	} front_ctl_t;

	typedef struct packed {
		logic pop;
		logic avail;
	} back_ctl_t;

endpackage
`default_nettype wire

### rtl/ucd_front.sv
`default_nettype none
module ucd_front
	import ucd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic              q_full,
	output front_ctl_t             ctl,
	output op_t                    op
);

	logic [1:0] bytes_left_q;
	logic [1:0] bytes_left_d;
	logic       accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign ctl.push = accept;

	always_comb begin
		op.kind      = OP_BAD;
		op.last      = 1'b0;
		op.payload   = '0;
		bytes_left_d = bytes_left_q;
		if (bytes_left_q != 2'd0) begin
			// absorb any byte as a continuation, top bits unchecked
			op.kind      = OP_CONT;
			op.last      = (bytes_left_q == 2'd1);
			op.payload   = PAY_W'(in_byte[CONT_BITS-1:0]);
			bytes_left_d = bytes_left_q - 2'd1;
		end else begin
			unique case (in_byte) inside
				8'b0???????: begin
					op.kind    = OP_ASCII;
					op.payload = in_byte[PAY_W-1:0];
				end
				8'b110?????: begin
					op.kind      = OP_LEAD;
					op.payload   = PAY_W'(in_byte[4:0]);
					bytes_left_d = 2'd1;
				end
				8'b1110????: begin
					op.kind      = OP_LEAD;
					op.payload   = PAY_W'(in_byte[3:0]);
					bytes_left_d = 2'd2;
				end
				8'b11110???: begin
					op.kind      = OP_LEAD;
					op.payload   = PAY_W'(in_byte[2:0]);
					bytes_left_d = 2'd3;
				end
				default: begin
					op.kind = OP_BAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 2'd0;
		end else if (accept) begin
			bytes_left_q <= bytes_left_d;
		end
	end

endmodule
`default_nettype wire

### rtl/ucd_queue.sv
`default_nettype none
module ucd_queue
	import ucd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire front_ctl_t fctl,
	input  wire op_t        wr_op,
	output logic            full,
	input  wire logic       pop,
	output back_ctl_t       bctl,
	output op_t             rd_op
);

	op_t               entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign bctl.avail = (count_q != '0);
	assign do_pop    = pop && bctl.avail;
	assign bctl.pop  = do_pop;
	assign rd_op     = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (fctl.push) begin
			entries_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (fctl.push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (fctl.push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!fctl.push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/ucd_back.sv
`default_nettype none
module ucd_back
	import ucd_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire back_ctl_t       bctl,
	input  wire op_t             op,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [CP_W-1:0]      code_point,
	output logic                 bad_lead
);

	logic [CP_W-1:0] partial_q;
	logic [CP_W-1:0] cp_q;
	logic            bad_q;
	logic            out_valid_q;
	logic            emits;
	logic            slot_free;
	logic [CP_W-1:0] shifted;
	logic [CP_W-1:0] cp_d;

	assign shifted   = {partial_q[CP_W-CONT_BITS-1:0], op.payload[CONT_BITS-1:0]};
	assign emits     = (op.kind != OP_LEAD) && !((op.kind == OP_CONT) && !op.last);
	assign slot_free = !out_valid_q || !out_stall;
	// no-result items never wait on the output register
	assign pop       = bctl.avail && (!emits || slot_free);

	always_comb begin
		unique case (op.kind)
			OP_ASCII: cp_d = CP_W'(op.payload);
			OP_CONT:  cp_d = shifted;
			OP_BAD:   cp_d = SUBST_CP;
			default:  cp_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (bctl.pop) begin
				unique case (op.kind)
					OP_LEAD: partial_q <= CP_W'(op.payload);
					OP_CONT: partial_q <= op.last ? '0 : shifted;
					default: partial_q <= partial_q;
				endcase
			end
			if (bctl.pop && emits) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bctl.pop && emits) begin
			cp_q  <= cp_d;
			bad_q <= (op.kind == OP_BAD);
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = cp_q;
	assign bad_lead   = bad_q;

endmodule
`default_nettype wire

### rtl/utf8_codepoint_decoder_core.sv
`default_nettype none
// UTF-8 to code point decoder. Bytes enter on in_byte under valid/stall and
// decoded code points leave on code_point/bad_lead under valid/stall. One byte
// is taken per clock in steady state when out_stall stays low; the rate is set
// by the classifier and the assembler, which run apart through a two-entry
// queue. An ASCII byte gives a result; a lead byte 110xxxxx, 1110xxxx or
// 11110xxx opens a 2, 3 or 4 byte sequence that gives one result on its last
// byte. Bytes after a lead byte are always taken as continuation bytes with
// their top two bits ignored. A stray continuation byte or a byte 0xF8..0xFF
// at a lead position gives 0x3F with bad_lead high. Overlong forms, surrogates
// and values above 0x10FFFF pass through unchecked. A result passes through
// the queue and then the output register, where it stays visible until taken.
module utf8_codepoint_decoder_core
	import ucd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] in_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [CP_W-1:0]        code_point,
	output logic                   bad_lead
);

	front_ctl_t fctl;
	back_ctl_t  bctl;
	op_t        f_op;
	op_t        b_op;
	logic       q_full;
	logic       b_pop;

	// classify each request and track how many continuation bytes remain
	ucd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.ctl      (fctl),
		.op       (f_op)
	);

	// decouple classifier from assembler so each can stall on its own
	ucd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.fctl   (fctl),
		.wr_op  (f_op),
		.full   (q_full),
		.pop    (b_pop),
		.bctl   (bctl),
		.rd_op  (b_op)
	);

	// assemble the code point and hold the result in the output register
	ucd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.bctl       (bctl),
		.op         (b_op),
		.pop        (b_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.bad_lead   (bad_lead)
	);

endmodule
`default_nettype wire

### sim/tb_utf8_codepoint_decoder_core.sv
`timescale 1ns / 1ps

module tb_utf8_codepoint_decoder_core;
	import ucd_pkg::*;

	// Clock period, reset length, and how long to watch the outputs once the
	// last expected code point has come out (a result passes through the queue
	// and the output register after its byte is taken).
	localparam int unsigned HALF_PERIOD   = 6;
	localparam int unsigned RESET_CYCLES  = 10;
	localparam int unsigned DRAIN_CYCLES  = 24;
	localparam int unsigned RANDOM_BYTES  = 1850;
	localparam int unsigned IDLE_PCT      = 22;
	localparam int unsigned CALM_FIRST    = 700;
	localparam int unsigned CALM_LAST     = 1200;
	localparam int unsigned DIRECTED_ROWS = 25;
	localparam int unsigned STREAM_MAX    = DIRECTED_ROWS + RANDOM_BYTES + 4;

	// Lead byte tags, compared against the top bits of a byte at a lead position
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [4:0] LEAD4_TAG = 5'b11110;
	localparam logic [1:0] CONT_TAG  = 2'b10;

	// One request on the byte channel; when fixed is set, cp and bad hold the
	// result written out by hand and replace the predicted one.
	typedef struct packed {
		logic [BYTE_W-1:0] in_b;
		logic              fixed;
		logic [CP_W-1:0]   cp;
		logic              bad;
	} stim_t;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            bad;
	} decoded_t;

	// Directed stream: extremes of ASCII, bad lead bytes (stray continuation,
	// 0xF8 and above), an overlong zero, the top of each sequence length, a
	// 4-byte sequence whose continuations look like lead bytes, and a lead-like
	// byte taken as a continuation inside a 2-byte sequence.
	localparam stim_t DIRECTED_TBL [DIRECTED_ROWS] = '{
		'{8'h00, 1'b1, 21'h000000, 1'b0},
		'{8'h7F, 1'b1, 21'h00007F, 1'b0},
		'{8'h80, 1'b1, SUBST_CP,   1'b1},
		'{8'hF8, 1'b1, SUBST_CP,   1'b1},
		'{8'hFF, 1'b1, SUBST_CP,   1'b1},
		'{8'hC0, 1'b0, 21'h0,      1'b0},
		'{8'h80, 1'b0, 21'h0,      1'b0},
		'{8'hDF, 1'b0, 21'h0,      1'b0},
		'{8'hBF, 1'b0, 21'h0,      1'b0},
		'{8'hE0, 1'b0, 21'h0,      1'b0},
		'{8'h80, 1'b0, 21'h0,      1'b0},
		'{8'h80, 1'b0, 21'h0,      1'b0},
		'{8'hEF, 1'b0, 21'h0,      1'b0},
		'{8'hBF, 1'b0, 21'h0,      1'b0},
		'{8'hBF, 1'b0, 21'h0,      1'b0},
		'{8'hF0, 1'b0, 21'h0,      1'b0},
		'{8'h90, 1'b0, 21'h0,      1'b0},
		'{8'h80, 1'b0, 21'h0,      1'b0},
		'{8'h80, 1'b0, 21'h0,      1'b0},
		'{8'hF7, 1'b0, 21'h0,      1'b0},
		'{8'hFF, 1'b0, 21'h0,      1'b0},
		'{8'hFF, 1'b0, 21'h0,      1'b0},
		'{8'hFF, 1'b0, 21'h0,      1'b0},
		'{8'hC3, 1'b0, 21'h0,      1'b0},
		'{8'hE9, 1'b0, 21'h0,      1'b0}
	};

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] in_byte   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [CP_W-1:0]   code_point;
	logic              bad_lead;

	// Byte stream to send, results still owed by the decoder, and counters
	stim_t       byte_stream [STREAM_MAX];
	decoded_t    owed_tbl [STREAM_MAX];
	int unsigned stream_len = 0;
	int unsigned owed_wr    = 0;
	int unsigned owed_rd    = 0;
	int unsigned next_idx   = 0;
	int unsigned acc_idx    = 0;
	int unsigned fail_cnt   = 0;

	// Predictor state: continuation bytes still owed and the partial code point
	logic [1:0]      cont_left = 2'd0;
	logic [CP_W-1:0] cp_acc    = '0;

	utf8_codepoint_decoder_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.bad_lead   (bad_lead)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// Append one request to the byte stream
	task automatic stream_add(input stim_t s);
		byte_stream[stream_len] = s;
		stream_len = stream_len + 1;
	endtask

	// Record one result the decoder still owes
	task automatic owed_add(input logic [CP_W-1:0] cp, input logic bad);
		owed_tbl[owed_wr].cp  = cp;
		owed_tbl[owed_wr].bad = bad;
		owed_wr = owed_wr + 1;
	endtask

	// Advance the predictor by one accepted byte; emits tells whether the byte
	// completes a code point (or is a bad lead byte).
	task automatic decode_byte(input logic [BYTE_W-1:0] b, output bit emits,
			output logic [CP_W-1:0] cp, output logic bad);
		emits = 1'b0;
		cp    = '0;
		bad   = 1'b0;
		if (cont_left != 2'd0) begin
			// Inside a sequence every byte is a continuation; ignore its top bits
			cp_acc    = {cp_acc[CP_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0) begin
				emits  = 1'b1;
				cp     = cp_acc;
				cp_acc = '0;
			end
		end else if (b[7] == 1'b0) begin
			emits = 1'b1;
			cp    = CP_W'(b);
		end else if (b[7:5] == LEAD2_TAG) begin
			cp_acc    = CP_W'(b[4:0]);
			cont_left = 2'd1;
		end else if (b[7:4] == LEAD3_TAG) begin
			cp_acc    = CP_W'(b[3:0]);
			cont_left = 2'd2;
		end else if (b[7:3] == LEAD4_TAG) begin
			cp_acc    = CP_W'(b[2:0]);
			cont_left = 2'd3;
		end else begin
			// Stray continuation or 0xF8..0xFF at a lead position
			emits = 1'b1;
			cp    = SUBST_CP;
			bad   = 1'b1;
		end
	endtask

	// Roll for an idle cycle; nobody idles inside the calm window
	function automatic bit idle_roll();
		if (acc_idx >= CALM_FIRST && acc_idx < CALM_LAST)
			return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	function automatic stim_t plain_byte(input logic [BYTE_W-1:0] b);
		stim_t s;
		s      = '0;
		s.in_b = b;
		return s;
	endfunction

	// Queue a continuation byte: mostly well formed, sometimes with random top
	// bits, which the decoder must absorb all the same.
	task automatic add_cont();
		logic [BYTE_W-1:0] b;
		if ($urandom_range(99) < 8)
			b = BYTE_W'($urandom_range(255));
		else
			b = {CONT_TAG, 6'($urandom_range(63))};
		stream_add(plain_byte(b));
	endtask

	// Build the random stream: mostly complete sequences with random payload,
	// the rest noise bytes and bad lead bytes.
	task automatic build_random_stream();
		int unsigned target;
		int unsigned pick;
		target = stream_len + RANDOM_BYTES;
		while (stream_len < target) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				stream_add(plain_byte({1'b0, 7'($urandom_range(127))}));
			end else if (pick < 50) begin
				stream_add(plain_byte({LEAD2_TAG, 5'($urandom_range(31))}));
				add_cont();
			end else if (pick < 68) begin
				stream_add(plain_byte({LEAD3_TAG, 4'($urandom_range(15))}));
				repeat (2) add_cont();
			end else if (pick < 85) begin
				stream_add(plain_byte({LEAD4_TAG, 3'($urandom_range(7))}));
				repeat (3) add_cont();
			end else if (pick < 93) begin
				// Noise: any byte at all
				stream_add(plain_byte(BYTE_W'($urandom_range(255))));
			end else if (pick < 97) begin
				// Stray continuation byte at a lead position
				stream_add(plain_byte({CONT_TAG, 6'($urandom_range(63))}));
			end else begin
				// Lead bytes past the 4-byte form
				stream_add(plain_byte({5'b11111, 3'($urandom_range(7))}));
			end
		end
	endtask

	// Byte side: predict each accepted request, then offer the next byte or idle.
	// Hold valid and the byte while the decoder stalls.
	always @(posedge clk) begin : byte_driver
		bit              emits;
		logic [CP_W-1:0] cp;
		logic            bad;
		stim_t           row;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				row = byte_stream[acc_idx];
				decode_byte(in_byte, emits, cp, bad);
				if (row.fixed)
					owed_add(row.cp, row.bad);
				else if (emits)
					owed_add(cp, bad);
				acc_idx = acc_idx + 1;
			end
			if (!in_valid || !in_stall) begin
				if (next_idx < stream_len && !idle_roll()) begin
					in_valid <= 1'b1;
					in_byte  <= byte_stream[next_idx].in_b;
					next_idx = next_idx + 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result side: compare each taken result with the oldest expectation,
	// then stall at random for the next cycle.
	always @(posedge clk) begin : result_check
		decoded_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (owed_rd == owed_wr) begin
					$error("unexpected result: code_point %h bad_lead %b", code_point,
						bad_lead);
					fail_cnt = fail_cnt + 1;
				end else begin
					want    = owed_tbl[owed_rd];
					owed_rd = owed_rd + 1;
					if (code_point !== want.cp) begin
						$error("code_point: expected %h, actual %h", want.cp, code_point);
						fail_cnt = fail_cnt + 1;
					end
					if (bad_lead !== want.bad) begin
						$error("bad_lead: expected %b, actual %b", want.bad, bad_lead);
						fail_cnt = fail_cnt + 1;
					end
				end
			end
			out_stall <= idle_roll();
		end
	end

	initial begin : main_seq
		// Walk the directed table first, then append the random stream
		for (int i = 0; i < DIRECTED_ROWS; i++)
			stream_add(DIRECTED_TBL[i]);
		build_random_stream();

		// Hold reset, then release it on a rising edge
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every byte is taken and every result has come out
		while (acc_idx < stream_len || owed_rd != owed_wr)
			@(posedge clk);

		// Watch a little longer for results that should not exist
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_cnt == 0)
			$display("utf8_codepoint_decoder_core regression: pass");
		else
			$display("utf8_codepoint_decoder_core regression: fail");
		$finish;
	end

	// Drop the run if it hangs
	initial begin : watchdog
		#5_000_000;
		$display("utf8_codepoint_decoder_core regression: fail");
		$finish;
	end

endmodule
